### sv/bcc_pkg.sv
// Shared constants, types and helpers for the barycentric weight pipeline.
`default_nettype none
package bcc_pkg;

  // Input coordinate width and weight fraction bits
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 24;
  localparam int N_COORD    = 12;
  localparam int N_DOT      = 5;
  localparam int N_PROD     = 6;

  // Stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = ((N_COORD * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int DPROD_W = 2 * DIFF_W;
  localparam int DOT_W   = 2 * DIFF_W + 3;
  localparam int HALF_W  = DOT_W / 2;
  localparam int HI_W    = DOT_W - HALF_W;
  localparam int PART_W  = 2 * HI_W + 1;
  localparam int PROD_W  = 2 * DOT_W;
  localparam int NMAG_W  = PROD_W - 1;
  localparam int DEN_W   = NMAG_W;
  localparam int NUM_W   = NMAG_W + FRAC_BITS;
  localparam int QM_W    = NUM_W + 1;
  localparam int VS_W    = QM_W + 1;
  localparam int U_W     = VS_W + 2;

  typedef logic signed [DOT_W-1:0] dot_t;

  // Sideband carried through the divider
  typedef struct packed {
    logic degen;
    logic neg_v;
    logic neg_w;
  } div_tag_t;

  // One result word
  typedef struct packed {
    logic             degen;
    logic [OUT_W-1:0] weight_w;
    logic [OUT_W-1:0] weight_v;
    logic [OUT_W-1:0] weight_u;
  } res_t;

  // Clamp a wide signed weight to the output range
  function automatic logic [OUT_W-1:0] sat_out(input logic signed [U_W-1:0] x);
    logic [U_W-OUT_W:0] hi;
    logic [OUT_W-1:0]   r;
    hi = x[U_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      r = x[OUT_W-1:0];
    end else if (x[U_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/bcc_dot.sv
// Edge vectors and the five dot products, three register stages.
`default_nettype none
module bcc_dot (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          ce_i,
  input  wire                                          valid_i,
  input  wire [bcc_pkg::N_COORD*bcc_pkg::COORD_BITS-1:0] coords_i,
  output logic                                         valid_o,
  output bcc_pkg::dot_t                                d_o [bcc_pkg::N_DOT]
);

  localparam int CB = bcc_pkg::COORD_BITS;

  logic signed [bcc_pkg::DIFF_W-1:0]  ab_r [3];
  logic signed [bcc_pkg::DIFF_W-1:0]  ac_r [3];
  logic signed [bcc_pkg::DIFF_W-1:0]  ap_r [3];
  logic signed [bcc_pkg::DPROD_W-1:0] pr_r [bcc_pkg::N_DOT][3];
  bcc_pkg::dot_t                      d_r  [bcc_pkg::N_DOT];
  logic                               v1_r, v2_r, v3_r;

  // Form AB, AC and AP per axis
  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [CB-1:0] p, a, b, c;
    assign p = coords_i[k*CB +: CB];
    assign a = coords_i[(3+k)*CB +: CB];
    assign b = coords_i[(6+k)*CB +: CB];
    assign c = coords_i[(9+k)*CB +: CB];

    always_ff @(posedge clk) begin
      if (ce_i) begin
        ab_r[k] <= bcc_pkg::DIFF_W'(b) - bcc_pkg::DIFF_W'(a);
        ac_r[k] <= bcc_pkg::DIFF_W'(c) - bcc_pkg::DIFF_W'(a);
        ap_r[k] <= bcc_pkg::DIFF_W'(p) - bcc_pkg::DIFF_W'(a);
      end
    end

    // Per-axis products
    always_ff @(posedge clk) begin
      if (ce_i) begin
        pr_r[0][k] <= ab_r[k] * ab_r[k];
        pr_r[1][k] <= ab_r[k] * ac_r[k];
        pr_r[2][k] <= ac_r[k] * ac_r[k];
        pr_r[3][k] <= ap_r[k] * ab_r[k];
        pr_r[4][k] <= ap_r[k] * ac_r[k];
      end
    end
  end

  // Sum the three axes
  for (genvar j = 0; j < bcc_pkg::N_DOT; j++) begin : g_sum
    always_ff @(posedge clk) begin
      if (ce_i) begin
        d_r[j] <= bcc_pkg::DOT_W'(pr_r[j][0]) + bcc_pkg::DOT_W'(pr_r[j][1])
                + bcc_pkg::DOT_W'(pr_r[j][2]);
      end
    end
    assign d_o[j] = d_r[j];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce_i) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign valid_o = v3_r;

endmodule
`default_nettype wire

### sv/bcc_gram.sv
// Gram determinant and weight numerators from split multiplies, four stages.
`default_nettype none
module bcc_gram (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         ce_i,
  input  wire                         valid_i,
  input  bcc_pkg::dot_t               d_i [bcc_pkg::N_DOT],
  output logic                        valid_o,
  output logic [bcc_pkg::DEN_W-1:0]   den_o,
  output logic [bcc_pkg::NMAG_W-1:0]  vmag_o,
  output logic [bcc_pkg::NMAG_W-1:0]  wmag_o,
  output bcc_pkg::div_tag_t           tag_o
);

  localparam int HW = bcc_pkg::HALF_W;
  localparam int PW = bcc_pkg::PROD_W;
  // Operand pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
  localparam int A_SEL [bcc_pkg::N_PROD] = '{0, 1, 2, 1, 0, 1};
  localparam int B_SEL [bcc_pkg::N_PROD] = '{2, 1, 3, 4, 4, 3};

  logic signed [bcc_pkg::PART_W-1:0] hh_r [bcc_pkg::N_PROD];
  logic signed [bcc_pkg::PART_W-1:0] hl_r [bcc_pkg::N_PROD];
  logic signed [bcc_pkg::PART_W-1:0] lh_r [bcc_pkg::N_PROD];
  logic signed [bcc_pkg::PART_W-1:0] ll_r [bcc_pkg::N_PROD];
  logic signed [PW-1:0]              prod_r [bcc_pkg::N_PROD];
  logic signed [PW:0]                den_r, vn_r, wn_r;
  logic [bcc_pkg::DEN_W-1:0]         den_o_r;
  logic [bcc_pkg::NMAG_W-1:0]        vmag_r, wmag_r;
  bcc_pkg::div_tag_t                 tag_r;
  logic                              v1_r, v2_r, v3_r, v4_r;
  logic signed [PW:0]                vabs_nxt, wabs_nxt;

  // Partial products and their recombination
  for (genvar k = 0; k < bcc_pkg::N_PROD; k++) begin : g_prod
    logic signed [bcc_pkg::HI_W-1:0] ah, bh;
    logic signed [HW:0]              al, bl;
    assign ah = d_i[A_SEL[k]][bcc_pkg::DOT_W-1:HW];
    assign bh = d_i[B_SEL[k]][bcc_pkg::DOT_W-1:HW];
    assign al = {1'b0, d_i[A_SEL[k]][HW-1:0]};
    assign bl = {1'b0, d_i[B_SEL[k]][HW-1:0]};

    always_ff @(posedge clk) begin
      if (ce_i) begin
        hh_r[k] <= ah * bh;
        hl_r[k] <= ah * bl;
        lh_r[k] <= al * bh;
        ll_r[k] <= al * bl;
      end
    end

    always_ff @(posedge clk) begin
      if (ce_i) begin
        prod_r[k] <= (PW'(hh_r[k]) <<< (2 * HW))
                   + ((PW'(hl_r[k]) + PW'(lh_r[k])) <<< HW)
                   + PW'(ll_r[k]);
      end
    end
  end

  // Determinant and numerators
  always_ff @(posedge clk) begin
    if (ce_i) begin
      den_r <= (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);
      vn_r  <= (PW+1)'(prod_r[2]) - (PW+1)'(prod_r[3]);
      wn_r  <= (PW+1)'(prod_r[4]) - (PW+1)'(prod_r[5]);
    end
  end

  // Split numerators into sign and magnitude
  always_comb begin
    vabs_nxt = vn_r[PW] ? -vn_r : vn_r;
    wabs_nxt = wn_r[PW] ? -wn_r : wn_r;
  end

  always_ff @(posedge clk) begin
    if (ce_i) begin
      den_o_r     <= den_r[bcc_pkg::DEN_W-1:0];
      vmag_r      <= vabs_nxt[bcc_pkg::NMAG_W-1:0];
      wmag_r      <= wabs_nxt[bcc_pkg::NMAG_W-1:0];
      tag_r.degen <= (den_r == '0);
      tag_r.neg_v <= vn_r[PW];
      tag_r.neg_w <= wn_r[PW];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce_i) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign valid_o = v4_r;
  assign den_o   = den_o_r;
  assign vmag_o  = vmag_r;
  assign wmag_o  = wmag_r;
  assign tag_o   = tag_r;

endmodule
`default_nettype wire

### sv/bcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing den.
`default_nettype none
module bcc_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         ce_i,
  input  wire                         valid_i,
  input  wire [bcc_pkg::DEN_W-1:0]    den_i,
  input  wire [bcc_pkg::NMAG_W-1:0]   vmag_i,
  input  wire [bcc_pkg::NMAG_W-1:0]   wmag_i,
  input  bcc_pkg::div_tag_t           tag_i,
  output logic                        valid_o,
  output logic [bcc_pkg::QM_W-1:0]    qv_o,
  output logic [bcc_pkg::QM_W-1:0]    qw_o,
  output bcc_pkg::div_tag_t           tag_o
);

  localparam int NW = bcc_pkg::NUM_W;
  localparam int DW = bcc_pkg::DEN_W;

  logic [DW-1:0]     rv_r  [1:NW];
  logic [DW-1:0]     rw_r  [1:NW];
  logic [NW-1:0]     nv_r  [1:NW];
  logic [NW-1:0]     nw_r  [1:NW];
  logic [DW-1:0]     den_r [1:NW];
  bcc_pkg::div_tag_t tag_r [1:NW];
  logic              vld_r [1:NW];

  // One quotient bit per stage; dividend bits shift out, quotient bits shift in
  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [DW-1:0]     rv_in, rw_in, den_in;
    logic [NW-1:0]     nv_in, nw_in;
    bcc_pkg::div_tag_t tag_in;
    logic              vld_in;
    logic [DW:0]       tv, tw, dv, dw;
    logic              gev, gew;

    if (s == 0) begin : g_first
      assign rv_in  = '0;
      assign rw_in  = '0;
      assign nv_in  = {vmag_i, {bcc_pkg::FRAC_BITS{1'b0}}};
      assign nw_in  = {wmag_i, {bcc_pkg::FRAC_BITS{1'b0}}};
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rv_in  = rv_r[s];
      assign rw_in  = rw_r[s];
      assign nv_in  = nv_r[s];
      assign nw_in  = nw_r[s];
      assign den_in = den_r[s];
      assign tag_in = tag_r[s];
      assign vld_in = vld_r[s];
    end

    assign tv  = {rv_in, nv_in[NW-1]};
    assign tw  = {rw_in, nw_in[NW-1]};
    assign dv  = tv - {1'b0, den_in};
    assign dw  = tw - {1'b0, den_in};
    assign gev = (tv >= {1'b0, den_in});
    assign gew = (tw >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (ce_i) begin
        rv_r[s+1]  <= gev ? dv[DW-1:0] : tv[DW-1:0];
        rw_r[s+1]  <= gew ? dw[DW-1:0] : tw[DW-1:0];
        nv_r[s+1]  <= {nv_in[NW-2:0], gev};
        nw_r[s+1]  <= {nw_in[NW-2:0], gew};
        den_r[s+1] <= den_in;
        tag_r[s+1] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (ce_i) begin
        vld_r[s+1] <= vld_in;
      end
    end
  end

  // Round half away from zero on the magnitude
  logic [NW-1:0]     qv1_r, qw1_r;
  logic              rbv_r, rbw_r, vld1_r, vld2_r;
  bcc_pkg::div_tag_t tag1_r, tag2_r;
  logic [bcc_pkg::QM_W-1:0] qv2_r, qw2_r;

  always_ff @(posedge clk) begin
    if (ce_i) begin
      qv1_r  <= nv_r[NW];
      qw1_r  <= nw_r[NW];
      rbv_r  <= ({rv_r[NW], 1'b0} >= {1'b0, den_r[NW]});
      rbw_r  <= ({rw_r[NW], 1'b0} >= {1'b0, den_r[NW]});
      tag1_r <= tag_r[NW];
      qv2_r  <= bcc_pkg::QM_W'(qv1_r) + bcc_pkg::QM_W'(rbv_r);
      qw2_r  <= bcc_pkg::QM_W'(qw1_r) + bcc_pkg::QM_W'(rbw_r);
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (ce_i) begin
      vld1_r <= vld_r[NW];
      vld2_r <= vld1_r;
    end
  end

  assign valid_o = vld2_r;
  assign qv_o    = qv2_r;
  assign qw_o    = qw2_r;
  assign tag_o   = tag2_r;

endmodule
`default_nettype wire

### sv/bcc_obuf.sv
// Two-word output buffer that decouples the pipeline from the receiver.
`default_nettype none
module bcc_obuf (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push_i,
  input  bcc_pkg::res_t data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  output bcc_pkg::res_t out_data_o,
  input  wire           out_ready_i
);

  logic [1:0]    count_r, count_nxt;
  bcc_pkg::res_t e0_r, e1_r;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_r != 2'd0);
  assign out_data_o  = e0_r;
  assign ready_o     = (count_r != 2'd2);

  // Track fill level
  always_comb begin
    count_nxt = count_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold, advance or load the entries
  always_ff @(posedge clk) begin
    if (pop) begin
      e0_r <= (push_i && count_r == 2'd1) ? data_i : e1_r;
      if (push_i && count_r == 2'd2) begin
        e1_r <= data_i;
      end
    end else if (push_i) begin
      if (count_r == 2'd0) begin
        e0_r <= data_i;
      end else begin
        e1_r <= data_i;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("output buffer level out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && count_r == 2'd2)) else $error("word pushed into full buffer");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push_i) |=> (count_r == $past(count_r) - 2'd1))
    else $error("buffer level wrong after a drain");

endmodule
`default_nettype wire

### sv/triangle_barycentric_coords.sv
// Top level: barycentric weights of a point against a 3D triangle, fully pipelined.
//
// Input word (in_t*): query point P and vertices A, B, C, twelve signed
// coordinates. Result word (out_t*): weights u, v, w as signed Q8.16, each
// saturated to 24 bits, and tuser high for a degenerate triangle (zero Gram
// determinant), in which case all three weights are zero.
// Throughput: one word per cycle; a new word is taken every cycle that
// in_tready is high. Pipeline stages: 3 of differences and dot products,
// 4 of split multiplies for the determinant and numerators, one
// restoring-division stage per quotient bit (89), 2 for rounding, 3 for
// signs, u and saturation, and 1 in the output buffer. The divider depth
// sets the latency.
// Stall: a two-word output buffer holds finished results; when it fills,
// in_tready drops and the whole pipeline holds without losing or repeating
// a word. Reset (rst_n low, synchronous) empties the pipeline and buffer.
`default_nettype none
module triangle_barycentric_coords (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
  input  wire [bcc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // weight_u, weight_v, weight_w
  output logic [bcc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // degenerate
  output logic [0:0]                        out_tuser
);

  logic                             ce, accept;
  logic                             dot_vld, gram_vld, div_vld;
  bcc_pkg::dot_t                    d [bcc_pkg::N_DOT];
  logic [bcc_pkg::DEN_W-1:0]        den;
  logic [bcc_pkg::NMAG_W-1:0]       vmag, wmag;
  bcc_pkg::div_tag_t                gtag, dtag;
  logic [bcc_pkg::QM_W-1:0]         qv, qw;

  logic signed [bcc_pkg::VS_W-1:0]  v1_r, w1_r, v2_r, w2_r;
  logic signed [bcc_pkg::U_W-1:0]   u2_r;
  logic                             dg1_r, dg2_r;
  logic                             s1_vld_r, s2_vld_r, s3_vld_r;
  bcc_pkg::res_t                    res_r, res_nxt, buf_data;

  assign in_tready = ce;
  assign accept    = in_tvalid && ce;

  bcc_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce_i     (ce),
    .valid_i  (accept),
    .coords_i (in_tdata[bcc_pkg::N_COORD*bcc_pkg::COORD_BITS-1:0]),
    .valid_o  (dot_vld),
    .d_o      (d)
  );

  bcc_gram u_gram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce_i    (ce),
    .valid_i (dot_vld),
    .d_i     (d),
    .valid_o (gram_vld),
    .den_o   (den),
    .vmag_o  (vmag),
    .wmag_o  (wmag),
    .tag_o   (gtag)
  );

  bcc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce_i    (ce),
    .valid_i (gram_vld),
    .den_i   (den),
    .vmag_i  (vmag),
    .wmag_i  (wmag),
    .tag_i   (gtag),
    .valid_o (div_vld),
    .qv_o    (qv),
    .qw_o    (qw),
    .tag_o   (dtag)
  );

  // Apply signs, form u, then clamp
  always_comb begin
    res_nxt.degen    = dg2_r;
    res_nxt.weight_u = dg2_r ? '0 : bcc_pkg::sat_out(u2_r);
    res_nxt.weight_v = dg2_r ? '0 : bcc_pkg::sat_out(bcc_pkg::U_W'(v2_r));
    res_nxt.weight_w = dg2_r ? '0 : bcc_pkg::sat_out(bcc_pkg::U_W'(w2_r));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      v1_r  <= dtag.neg_v ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      w1_r  <= dtag.neg_w ? -$signed({1'b0, qw}) : $signed({1'b0, qw});
      dg1_r <= dtag.degen;
      u2_r  <= (bcc_pkg::U_W'(1) <<< bcc_pkg::FRAC_BITS)
             - bcc_pkg::U_W'(v1_r) - bcc_pkg::U_W'(w1_r);
      v2_r  <= v1_r;
      w2_r  <= w1_r;
      dg2_r <= dg1_r;
      res_r <= res_nxt;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= div_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  bcc_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (ce && s3_vld_r),
    .data_i      (res_r),
    .ready_o     (ce),
    .out_valid_o (out_tvalid),
    .out_data_o  (buf_data),
    .out_ready_i (out_tready)
  );

  assign out_tdata = bcc_pkg::OUT_DATA_W'({buf_data.weight_w, buf_data.weight_v,
                                           buf_data.weight_u});
  assign out_tuser = buf_data.degen;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("degenerate word carries non-zero weights");

endmodule
`default_nettype wire

### dv/triangle_barycentric_coords_test.sv
// Self-checking testbench for the barycentric weight pipeline.
`timescale 1ns / 1ps
module triangle_barycentric_coords_test;

  localparam int N_RANDOM  = 1430;
  localparam int IDLE_MAX  = 8;
  localparam int WDOG_MAX  = 4000;
  localparam int DRAIN_CYC = 200;

  typedef logic signed [bcc_pkg::COORD_BITS-1:0] coord_t;

  // One triangle query: P, A, B, C
  typedef struct {
    coord_t c[bcc_pkg::N_COORD];
  } query_t;

  // One set of weights
  typedef struct packed {
    logic [bcc_pkg::OUT_W-1:0] u;
    logic [bcc_pkg::OUT_W-1:0] v;
    logic [bcc_pkg::OUT_W-1:0] w;
    logic                      degen;
  } weights_t;

  // Directed row: a query and, where obvious, its weights
  typedef struct {
    query_t   q;
    bit       fixed;
    weights_t exp_w;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [bcc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bcc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                     out_tuser;

  weights_t pending_weights[$];
  int       n_mismatch = 0;
  int       n_unexpected = 0;
  int       quiet_cycles = 0;
  bit       send_done = 1'b0;
  bit       hold_off = 1'b0;

  triangle_barycentric_coords u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Round num * 2^FRAC / den to nearest, ties away from zero; den > 0
  function automatic logic signed [255:0] div_round(input logic signed [255:0] num,
                                                    input logic signed [255:0] den);
    logic signed [255:0] mag, q, r;
    mag = (num < 0) ? -num : num;
    mag = mag <<< bcc_pkg::FRAC_BITS;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    return (num < 0) ? -q : q;
  endfunction

  // Clamp to the 24-bit output range
  function automatic logic [bcc_pkg::OUT_W-1:0] clamp_weight(
      input logic signed [255:0] x);
    logic signed [255:0] lim;
    lim = 256'sd1 <<< (bcc_pkg::OUT_W - 1);
    if (x >= lim) return {1'b0, {(bcc_pkg::OUT_W-1){1'b1}}};
    if (x < -lim) return {1'b1, {(bcc_pkg::OUT_W-1){1'b0}}};
    return x[bcc_pkg::OUT_W-1:0];
  endfunction

  // Work out the barycentric weights of one query
  function automatic weights_t barycentric(input query_t q);
    logic signed [255:0] ab[3], ac[3], ap[3];
    logic signed [255:0] d00, d01, d11, d20, d21, den, v, w, u;
    weights_t r;
    for (int k = 0; k < 3; k++) begin
      ab[k] = 256'(q.c[6+k]) - 256'(q.c[3+k]);
      ac[k] = 256'(q.c[9+k]) - 256'(q.c[3+k]);
      ap[k] = 256'(q.c[k]) - 256'(q.c[3+k]);
    end
    d00 = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
    d01 = ab[0]*ac[0] + ab[1]*ac[1] + ab[2]*ac[2];
    d11 = ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2];
    d20 = ap[0]*ab[0] + ap[1]*ab[1] + ap[2]*ab[2];
    d21 = ap[0]*ac[0] + ap[1]*ac[1] + ap[2]*ac[2];
    den = d00 * d11 - d01 * d01;
    if (den == 0) begin
      r = '{u: '0, v: '0, w: '0, degen: 1'b1};
      return r;
    end
    v = div_round(d11 * d20 - d01 * d21, den);
    w = div_round(d00 * d21 - d01 * d20, den);
    u = (256'sd1 <<< bcc_pkg::FRAC_BITS) - v - w;
    r.u = clamp_weight(u);
    r.v = clamp_weight(v);
    r.w = clamp_weight(w);
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic logic [bcc_pkg::IN_DATA_W-1:0] pack_query(input query_t q);
    logic [bcc_pkg::IN_DATA_W-1:0] d;
    d = '0;
    for (int k = 0; k < bcc_pkg::N_COORD; k++)
      d[k*bcc_pkg::COORD_BITS +: bcc_pkg::COORD_BITS] = q.c[k];
    return d;
  endfunction

  function automatic query_t make_query(input int p0, p1, p2, a0, a1, a2,
                                        b0, b1, b2, c0, c1, c2);
    query_t q;
    q.c = '{coord_t'(p0), coord_t'(p1), coord_t'(p2), coord_t'(a0), coord_t'(a1),
            coord_t'(a2), coord_t'(b0), coord_t'(b1), coord_t'(b2), coord_t'(c0),
            coord_t'(c1), coord_t'(c2)};
    return q;
  endfunction

  function automatic coord_t rand_coord(input int span);
    if (span >= 65536) return coord_t'($urandom);
    return coord_t'($urandom_range(span) - span / 2);
  endfunction

  // Mostly healthy triangles of mixed scale, some degenerate and extreme ones
  function automatic query_t random_query();
    query_t q;
    int span, mode;
    mode = $urandom_range(99);
    span = (mode < 30) ? 65536 : (1 << $urandom_range(15, 1));
    for (int k = 0; k < bcc_pkg::N_COORD; k++) q.c[k] = rand_coord(span);
    if (mode >= 90 && mode < 95) begin
      // collinear: C on the line through A and B
      for (int k = 0; k < 3; k++) begin
        q.c[3+k] = rand_coord(4096);
        q.c[6+k] = q.c[3+k] + rand_coord(256);
        q.c[9+k] = q.c[3+k] + 2 * (q.c[6+k] - q.c[3+k]);
      end
    end else if (mode >= 95) begin
      for (int k = 0; k < bcc_pkg::N_COORD; k++)
        q.c[k] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    int gap;
    gap = $urandom_range(IDLE_MAX);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= pack_query(q);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_weights.push_back(barycentric(q));
    @(negedge clk);
  endtask

  // Stimulus: directed table, then random queries
  initial begin
    row_t rows[$];
    weights_t zero_degen;
    zero_degen = '{u: '0, v: '0, w: '0, degen: 1'b1};
    // all points coincident at the origin and at each extreme
    rows.push_back('{make_query(0,0,0, 0,0,0, 0,0,0, 0,0,0), 1'b1, zero_degen});
    rows.push_back('{make_query(32767,32767,32767, 32767,32767,32767,
                                32767,32767,32767, 32767,32767,32767), 1'b1, zero_degen});
    rows.push_back('{make_query(-32768,-32768,-32768, -32768,-32768,-32768,
                                -32768,-32768,-32768, -32768,-32768,-32768), 1'b1,
                     zero_degen});
    // collinear vertices
    rows.push_back('{make_query(5,5,5, 0,0,0, 1,1,1, 2,2,2), 1'b1, zero_degen});
    // P at each vertex of a unit right triangle
    rows.push_back('{make_query(0,0,0, 0,0,0, 1,0,0, 0,1,0), 1'b1,
                     '{u: 24'h010000, v: '0, w: '0, degen: 1'b0}});
    rows.push_back('{make_query(1,0,0, 0,0,0, 1,0,0, 0,1,0), 1'b1,
                     '{u: '0, v: 24'h010000, w: '0, degen: 1'b0}});
    rows.push_back('{make_query(0,1,0, 0,0,0, 1,0,0, 0,1,0), 1'b1,
                     '{u: '0, v: '0, w: 24'h010000, degen: 1'b0}});
    // P far outside a tiny triangle: weights saturate
    rows.push_back('{make_query(32767,32767,0, 0,0,0, 1,0,0, 0,1,0), 1'b0, zero_degen});
    rows.push_back('{make_query(-32768,-32768,0, 0,0,0, 1,0,0, 0,1,0), 1'b0, zero_degen});
    // largest triangle spanning the full range
    rows.push_back('{make_query(0,0,0, -32768,-32768,-32768, 32767,-32768,-32768,
                                -32768,32767,32767), 1'b0, zero_degen});
    rows.push_back('{make_query(32767,-32768,32767, 32767,32767,-32768, -32768,32767,32767,
                                -32768,-32768,-32768), 1'b0, zero_degen});
    // rounding cases: thirds and halves
    rows.push_back('{make_query(1,1,0, 0,0,0, 3,0,0, 0,3,0), 1'b0, zero_degen});
    rows.push_back('{make_query(1,1,1, 0,0,0, 2,0,0, 0,2,0), 1'b0, zero_degen});
    rows.push_back('{make_query(-1,-1,0, 0,0,0, 3,0,0, 0,3,0), 1'b0, zero_degen});
    rows.push_back('{make_query(7,-3,9, 1,2,3, -4,5,6, 7,-8,9), 1'b0, zero_degen});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].fixed && barycentric(rows[i].q) !== rows[i].exp_w) begin
        n_mismatch++;
        $display("directed row %0d: predictor disagrees with table", i);
      end
      send_query(rows[i].q);
    end

    // Random queries; a long receiver hold-off starts part-way through
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      send_query(random_query());
    end
    in_tvalid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if ($urandom_range(2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(IDLE_MAX)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    weights_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_weights.size() == 0) begin
        n_unexpected++;
        $display("unexpected result word u=%h v=%h w=%h degen=%b",
                 out_tdata[0 +: bcc_pkg::OUT_W], out_tdata[bcc_pkg::OUT_W +: bcc_pkg::OUT_W],
                 out_tdata[2*bcc_pkg::OUT_W +: bcc_pkg::OUT_W], out_tuser[0]);
      end else begin
        want = pending_weights.pop_front();
        if (out_tdata[0 +: bcc_pkg::OUT_W] !== want.u ||
            out_tdata[bcc_pkg::OUT_W +: bcc_pkg::OUT_W] !== want.v ||
            out_tdata[2*bcc_pkg::OUT_W +: bcc_pkg::OUT_W] !== want.w ||
            out_tuser[0] !== want.degen) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp u=%h v=%h w=%h degen=%b got u=%h v=%h w=%h degen=%b",
                     want.u, want.v, want.w, want.degen,
                     out_tdata[0 +: bcc_pkg::OUT_W],
                     out_tdata[bcc_pkg::OUT_W +: bcc_pkg::OUT_W],
                     out_tdata[2*bcc_pkg::OUT_W +: bcc_pkg::OUT_W], out_tuser[0]);
        end
      end
    end
  end

  // Watchdog and end of run
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("triangle_barycentric_coords regression: fail");
        $finish;
      end
      if (send_done && pending_weights.size() == 0) begin
        repeat (DRAIN_CYC) @(posedge clk);
        if (n_mismatch == 0 && n_unexpected == 0 && pending_weights.size() == 0)
          $display("triangle_barycentric_coords regression: pass");
        else
          $display("triangle_barycentric_coords regression: fail");
        $finish;
      end
    end
  end

endmodule
